FILE: hw/rtl/wlr_pkg.sv
// Shared types and constants for the windowed loss ratio estimator.
// Used by wlr_hist, wlr_div and the top level; depends on nothing else.
`default_nettype none

package wlr_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF     = 40;

    localparam int WINDOW_W = 40;
    localparam int COUNT_W  = 16;
    localparam int RATIO_W  = 24;
    localparam int FRAC_W   = 16;
    // Integer bits of the ratio; also the shift that splits the dividend.
    localparam int INT_W    = RATIO_W - FRAC_W;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1000000);
    localparam logic [RATIO_W-1:0]  RATIO_ONE    = RATIO_W'(1) << FRAC_W;
    localparam logic [RATIO_W-1:0]  RATIO_MAX    = {RATIO_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_SEND  = 2'd0,
        KIND_RETX  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Commands into one history FIFO; push and pop are never high together.
    typedef struct packed {
        logic push;
        logic pop;
    } t_hist_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/windowed_loss_ratio_estimator.sv
// Windowed loss ratio estimator, top level; uses wlr_pkg, wlr_hist and wlr_div.
// Input beats carry kind, packet_count and now_time on a valid/ready channel.
// A send or retransmit record is taken in its accept cycle and gives no result.
// A query prunes both histories of entries older than now_time - window_length,
// one entry per cycle from each history in parallel, then divides the
// retransmit total by the send total in a one-bit-per-cycle divider.
// The divider produces the ratio in 24 steps, one per quotient bit. Special cases
// (no sends, zero send total, saturation) skip the divider.
// Results leave through an output register on a valid/ready channel; while
// a result waits there, records are still taken, and a following query runs
// to completion and then holds until the register frees.
// window_length is written through i_cfg_wr_en/i_cfg_wr_data at any idle time.
// Reset empties both histories and loads a window of 1000000; the entry
// memories are not cleared, since only entries inside the fill are read.
`default_nettype none

module windowed_loss_ratio_estimator
    import wlr_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [WINDOW_W-1:0]  i_cfg_wr_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_kind,
    input  wire logic [COUNT_W-1:0]   i_packet_count,
    input  wire logic [TIME_BITS-1:0] i_now_time,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [RATIO_W-1:0]        o_loss_ratio,
    output logic                      o_no_sends
);

    localparam int TOTAL_W = COUNT_W + $clog2(HISTORY_DEPTH);
    localparam int CMP_W   = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRUNE = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [WINDOW_W-1:0] r_window;
    logic [CMP_W-1:0]    r_limit;
    logic                r_prune_en;
    logic [RATIO_W-1:0]  r_ratio, n_ratio;
    logic                r_nosend, n_nosend;
    logic                r_o_valid;
    logic [RATIO_W-1:0]  r_o_ratio;
    logic                r_o_nosend;

    logic                accept;
    t_kind               kind;
    t_hist_ctl           send_ctl, retx_ctl;
    logic                send_empty, retx_empty;
    logic [TOTAL_W-1:0]  send_total, retx_total;
    logic [TIME_BITS-1:0] send_head_time, retx_head_time;
    logic                send_pop, retx_pop;
    logic                prune_done;
    logic                ratio_sat;
    logic                div_start;
    logic                div_done;
    logic [RATIO_W-1:0]  div_q;
    logic                out_load;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign kind    = t_kind'(i_kind);

    assign send_pop = (r_state == ST_PRUNE) && r_prune_en && !send_empty
                   && (CMP_W'(send_head_time) < r_limit);
    assign retx_pop = (r_state == ST_PRUNE) && r_prune_en && !retx_empty
                   && (CMP_W'(retx_head_time) < r_limit);
    assign prune_done = (r_state == ST_PRUNE) && !send_pop && !retx_pop;

    assign send_ctl.push = accept && (kind == KIND_SEND);
    assign send_ctl.pop  = send_pop;
    assign retx_ctl.push = accept && (kind == KIND_RETX);
    assign retx_ctl.pop  = retx_pop;

    // The quotient overflows RATIO_W bits exactly when retx >= send * 2^INT_W.
    assign ratio_sat = ((TOTAL_W + INT_W)'(retx_total) >= {send_total, {INT_W{1'b0}}});
    assign div_start = prune_done && !send_empty && (send_total != '0) && !ratio_sat;

    assign out_load = (r_state == ST_DONE) && (!r_o_valid || i_ready);

    wlr_hist #(
        .DEPTH  (HISTORY_DEPTH),
        .TIME_W (TIME_BITS)
    ) u_send_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (send_ctl),
        .i_count      (i_packet_count),
        .i_time       (i_now_time),
        .o_empty      (send_empty),
        .o_total      (send_total),
        .o_head_time  (send_head_time)
    );

    wlr_hist #(
        .DEPTH  (HISTORY_DEPTH),
        .TIME_W (TIME_BITS)
    ) u_retx_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (retx_ctl),
        .i_count      (i_packet_count),
        .i_time       (i_now_time),
        .o_empty      (retx_empty),
        .o_total      (retx_total),
        .o_head_time  (retx_head_time)
    );

    // The upper dividend bits start as the remainder; the low bits are the
    // integer part's bottom bits of the retransmit total followed by zeros.
    wlr_div #(
        .DEN_W (TOTAL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (retx_total >> INT_W),
        .i_low      ({retx_total[INT_W-1:0], {FRAC_W{1'b0}}}),
        .i_divisor  (send_total),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state  = r_state;
        n_ratio  = r_ratio;
        n_nosend = r_nosend;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (kind == KIND_QUERY)) begin
                    n_state = ST_PRUNE;
                end
            end
            ST_PRUNE: begin
                if (prune_done) begin
                    if (send_empty) begin
                        n_nosend = 1'b1;
                        n_ratio  = retx_empty ? '0 : RATIO_ONE;
                        n_state  = ST_DONE;
                    end else if (send_total == '0) begin
                        n_nosend = 1'b0;
                        n_ratio  = (retx_total == '0) ? '0 : RATIO_MAX;
                        n_state  = ST_DONE;
                    end else if (ratio_sat) begin
                        n_nosend = 1'b0;
                        n_ratio  = RATIO_MAX;
                        n_state  = ST_DONE;
                    end else begin
                        n_nosend = 1'b0;
                        n_state  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_ratio = div_q;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_window  <= WINDOW_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ratio  <= n_ratio;
        r_nosend <= n_nosend;
        if (accept && (kind == KIND_QUERY)) begin
            // Nothing is pruned when the window reaches back before time zero.
            r_prune_en <= (CMP_W'(i_now_time) > CMP_W'(r_window));
            r_limit    <= CMP_W'(i_now_time) - CMP_W'(r_window);
        end
        if (out_load) begin
            r_o_ratio  <= r_ratio;
            r_o_nosend <= r_nosend;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_loss_ratio = r_o_ratio;
    assign o_no_sends   = r_o_nosend;

endmodule

`default_nettype wire

FILE: hw/rtl/wlr_hist.sv
// One timestamped history FIFO: a synchronous memory of (time, count) entries
// with head pointer, fill count and running total. Depends on wlr_pkg.
`default_nettype none

module wlr_hist
    import wlr_pkg::*;
#(
    parameter int DEPTH  = HISTORY_DEPTH_DEF,
    parameter int TIME_W = TIME_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire t_hist_ctl                           i_ctl,
    input  wire logic [COUNT_W-1:0]                  i_count,
    input  wire logic [TIME_W-1:0]                   i_time,
    output logic                                     o_empty,
    output logic [COUNT_W+$clog2(DEPTH)-1:0]         o_total,
    output logic [TIME_W-1:0]                        o_head_time
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int TOTAL_W = COUNT_W + PTR_W;
    localparam int ENT_W   = TIME_W + COUNT_W;

    logic [ENT_W-1:0]   mem [DEPTH];

    logic [PTR_W-1:0]   r_head, n_head;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [ENT_W-1:0]   r_rd_data;

    logic               full;
    logic [PTR_W-1:0]   head_inc;
    logic [FILL_W:0]    tail_sum;
    logic [PTR_W-1:0]   tail;
    logic               wr_en;
    logic [ENT_W-1:0]   wr_data;
    logic [COUNT_W-1:0] head_count;

    assign full     = (r_fill == FILL_W'(DEPTH));
    assign o_empty  = (r_fill == '0);
    assign head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // The next free slot; when the FIFO is full it is the head itself.
    assign tail_sum = (FILL_W + 1)'(r_head) + (FILL_W + 1)'(r_fill);
    assign tail     = (tail_sum >= (FILL_W + 1)'(DEPTH))
                    ? PTR_W'(tail_sum - (FILL_W + 1)'(DEPTH))
                    : PTR_W'(tail_sum);

    assign wr_en   = i_ctl.push;
    assign wr_data = {i_time, i_count};

    always_comb begin
        n_head  = r_head;
        n_fill  = r_fill;
        n_total = r_total;
        if (i_ctl.push) begin
            if (full) begin
                // Overwrite the oldest entry and advance past it.
                n_head  = head_inc;
                n_total = r_total - TOTAL_W'(head_count) + TOTAL_W'(i_count);
            end else begin
                n_fill  = r_fill + 1'b1;
                n_total = r_total + TOTAL_W'(i_count);
            end
        end else if (i_ctl.pop) begin
            n_head  = head_inc;
            n_fill  = r_fill - 1'b1;
            n_total = r_total - TOTAL_W'(head_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[tail] <= wr_data;
        end
    end

    // The read port follows the next head, so the head entry is always
    // on the read register; a write to that same slot is forwarded.
    always_ff @(posedge i_clk) begin
        if (wr_en && (tail == n_head)) begin
            r_rd_data <= wr_data;
        end else begin
            r_rd_data <= mem[n_head];
        end
    end

    assign o_total     = r_total;
    assign o_head_time = r_rd_data[ENT_W-1:COUNT_W];
    assign head_count  = r_rd_data[COUNT_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/wlr_div.sv
// Restoring divider, one quotient bit per cycle, RATIO_W quotient bits.
// The caller guarantees the initial remainder is below the divisor. Depends on wlr_pkg.
`default_nettype none

module wlr_div
    import wlr_pkg::*;
#(
    parameter int DEN_W = COUNT_W + $clog2(HISTORY_DEPTH_DEF)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DEN_W-1:0]   i_rem_init,
    input  wire logic [RATIO_W-1:0] i_low,
    input  wire logic [DEN_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic [RATIO_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(RATIO_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [RATIO_W-1:0] r_q;

    logic [DEN_W:0]     rem2;
    logic [DEN_W:0]     diff;
    logic               ge;

    assign rem2 = {r_rem, r_q[RATIO_W-1]};
    assign ge   = (rem2 >= {1'b0, r_den});
    assign diff = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RATIO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend bits shift out of the top of r_q as quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_den <= i_divisor;
            r_q   <= i_low;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            r_q   <= {r_q[RATIO_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

FILE: test/loss_ratio_checker.sv
// Checker for the windowed loss ratio estimator: watches the config, input and result ports,
// keeps its own copy of both count histories and compares every result beat.
// Depends on wlr_pkg for widths, kinds and the ratio constants.
`timescale 1ns / 100ps

module loss_ratio_checker
    import wlr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [WINDOW_W-1:0]      i_cfg_wr_data,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire logic [1:0]               i_kind,
    input  wire logic [COUNT_W-1:0]       i_packet_count,
    input  wire logic [TIME_BITS_DEF-1:0] i_now_time,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire logic [RATIO_W-1:0]       i_loss_ratio,
    input  wire logic                     i_no_sends,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int DEPTH     = HISTORY_DEPTH_DEF;
    localparam int TW        = TIME_BITS_DEF;
    localparam int SEND_H    = 0;
    localparam int RETX_H    = 1;
    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               no_sends;
    } ratio_beat_t;

    logic [TW-1:0]       stamp_mem [2][DEPTH];
    logic [COUNT_W-1:0]  count_mem [2][DEPTH];
    int                  head_idx  [2];
    int                  fill_lvl  [2];
    longint unsigned     count_sum [2];
    logic [WINDOW_W-1:0] window_len;
    // Expected results in order; outside reset the write and read counts only grow.
    ratio_beat_t         ratio_expect_mem [EXP_DEPTH];
    int                  exp_wr_cnt = 0;
    int                  exp_rd_cnt = 0;

    function automatic void hist_drop(int h);
        if (fill_lvl[h] != 0) begin
            count_sum[h] -= count_mem[h][head_idx[h]];
            head_idx[h]   = (head_idx[h] + 1) % DEPTH;
            fill_lvl[h]--;
        end
    endfunction

    function automatic void hist_append(int h, logic [COUNT_W-1:0] cnt, logic [TW-1:0] stamp);
        int slot;
        if (fill_lvl[h] >= DEPTH)
            hist_drop(h);
        slot = (head_idx[h] + fill_lvl[h]) % DEPTH;
        stamp_mem[h][slot] = stamp;
        count_mem[h][slot] = cnt;
        fill_lvl[h]++;
        count_sum[h] += cnt;
    endfunction

    // Entries stamped strictly before now - window go; nothing goes while now <= window.
    function automatic void hist_trim(int h, logic [TW-1:0] now);
        logic [TW-1:0] oldest_kept;
        if (now <= window_len)
            return;
        oldest_kept = now - window_len;
        while (fill_lvl[h] != 0 && stamp_mem[h][head_idx[h]] < oldest_kept)
            hist_drop(h);
    endfunction

    function automatic ratio_beat_t estimate_ratio(logic [TW-1:0] now);
        ratio_beat_t     r;
        longint unsigned quot;
        hist_trim(SEND_H, now);
        hist_trim(RETX_H, now);
        if (fill_lvl[SEND_H] == 0) begin
            r.no_sends = 1'b1;
            r.ratio    = (fill_lvl[RETX_H] != 0) ? RATIO_ONE : '0;
        end else begin
            r.no_sends = 1'b0;
            if (count_sum[SEND_H] == 0) begin
                r.ratio = (count_sum[RETX_H] == 0) ? '0 : RATIO_MAX;
            end else begin
                quot    = (count_sum[RETX_H] << FRAC_W) / count_sum[SEND_H];
                r.ratio = (quot > RATIO_MAX) ? RATIO_MAX : quot[RATIO_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        ratio_beat_t want;
        if (!i_rst_n) begin
            for (int h = 0; h < 2; h++) begin
                head_idx[h]  = 0;
                fill_lvl[h]  = 0;
                count_sum[h] = 0;
            end
            window_len = WINDOW_RESET;
            exp_wr_cnt = 0;
            exp_rd_cnt = 0;
        end else begin
            if (i_cfg_wr_en)
                window_len = i_cfg_wr_data;

            // Results belong to earlier queries, so check them before taking this edge's input.
            if (i_out_valid && i_out_ready) begin
                if (exp_wr_cnt == exp_rd_cnt) begin
                    $error("unexpected result beat: loss_ratio %h, no_sends %b",
                           i_loss_ratio, i_no_sends);
                    o_fail_count++;
                end else begin
                    want = ratio_expect_mem[exp_rd_cnt % EXP_DEPTH];
                    exp_rd_cnt++;
                    if (i_loss_ratio !== want.ratio) begin
                        $error("loss_ratio: expected %h, actual %h", want.ratio, i_loss_ratio);
                        o_fail_count++;
                    end
                    if (i_no_sends !== want.no_sends) begin
                        $error("no_sends: expected %b, actual %b", want.no_sends, i_no_sends);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_SEND: begin
                        hist_append(SEND_H, i_packet_count, i_now_time);
                    end
                    KIND_RETX: begin
                        hist_append(RETX_H, i_packet_count, i_now_time);
                    end
                    KIND_QUERY: begin
                        ratio_expect_mem[exp_wr_cnt % EXP_DEPTH] = estimate_ratio(i_now_time);
                        exp_wr_cnt++;
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= exp_wr_cnt - exp_rd_cnt;
    end

endmodule

FILE: test/testbench.sv
// Top of the loss ratio estimator bench: clock, reset, stimulus and the final verdict.
// Instantiates windowed_loss_ratio_estimator and loss_ratio_checker; uses wlr_pkg.
`timescale 1ns / 100ps

module testbench;
    import wlr_pkg::*;

    localparam int            TW         = TIME_BITS_DEF;
    localparam logic [TW-1:0] LAST_STAMP = '1;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [WINDOW_W-1:0] i_cfg_wr_data  = '0;
    logic                i_valid        = 1'b0;
    logic [1:0]          i_kind         = KIND_NONE;
    logic [COUNT_W-1:0]  i_packet_count = '0;
    logic [TW-1:0]       i_now_time     = '0;
    logic                i_ready        = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [RATIO_W-1:0]  o_loss_ratio;
    logic                o_no_sends;

    int fail_count;
    int pending;
    bit calm       = 1'b0;
    int quiet_left = 0;
    int hold_left  = 0;

    always #5 i_clk = ~i_clk;

    windowed_loss_ratio_estimator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_packet_count (i_packet_count),
        .i_now_time     (i_now_time),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_loss_ratio   (o_loss_ratio),
        .o_no_sends     (o_no_sends)
    );

    loss_ratio_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_kind         (i_kind),
        .i_packet_count (i_packet_count),
        .i_now_time     (i_now_time),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_loss_ratio   (o_loss_ratio),
        .i_no_sends     (o_no_sends),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: ready runs of varying length broken by stalls of varying length.
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
        end else if (!i_ready) begin
            i_ready   <= 1'b1;
            hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(0, 20);
        end else begin
            i_ready   <= 1'b0;
            hold_left = $urandom_range(0, 11);
        end
    end

    task automatic send_beat(logic [1:0] kind, logic [COUNT_W-1:0] cnt, logic [TW-1:0] stamp);
        int gap;
        if (!calm) begin
            if (quiet_left > 0) begin
                quiet_left--;
            end else begin
                gap = $urandom_range(1, 12);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                quiet_left = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                         : $urandom_range(10, 60);
            end
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_packet_count <= cnt;
        i_now_time     <= stamp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Holds the sender until every query has been answered; extra extends the idle wait.
    task automatic wait_drained(int extra);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_window(logic [WINDOW_W-1:0] win);
        wait_drained(8);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= win;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(logic [WINDOW_W-1:0] win, int n_items, int unsigned step_max);
        logic [TW-1:0]      stamp;
        logic [COUNT_W-1:0] cnt;
        logic [1:0]         kind;
        int                 pick;
        write_window(win);
        stamp = TW'({$urandom(), $urandom()});
        for (int n = 0; n < n_items; n++) begin
            if (n == n_items / 2)
                wait_drained(0);
            if ($urandom_range(0, 63) == 0)
                stamp = stamp + TW'($urandom_range(0, step_max)) * 16;
            else if ($urandom_range(0, 199) == 0)
                stamp = stamp - TW'($urandom_range(0, step_max));
            else
                stamp = stamp + TW'($urandom_range(0, step_max));
            case ($urandom_range(0, 7))
                0:       cnt = '0;
                1:       cnt = '1;
                2, 3:    cnt = COUNT_W'($urandom_range(0, 15));
                default: cnt = COUNT_W'($urandom());
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 40)
                kind = KIND_SEND;
            else if (pick < 70)
                kind = KIND_RETX;
            else if (pick < 96)
                kind = KIND_QUERY;
            else
                kind = KIND_NONE;
            send_beat(kind, cnt, stamp);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with a short window so pruning is easy to steer.
        write_window(WINDOW_W'(100));
        send_beat(KIND_QUERY, '0, TW'(0));          // both histories empty
        send_beat(KIND_RETX, 16'd5, TW'(10));
        send_beat(KIND_QUERY, '0, TW'(10));         // no sends, retransmits held
        send_beat(KIND_SEND, '0, TW'(20));
        send_beat(KIND_QUERY, '0, TW'(20));         // send sum zero, retransmit sum not
        send_beat(KIND_SEND, '1, TW'(30));
        send_beat(KIND_QUERY, '0, TW'(30));
        send_beat(KIND_NONE, '1, LAST_STAMP);       // unused kind must change nothing
        send_beat(KIND_QUERY, '0, TW'(130));
        send_beat(KIND_SEND, 16'd1, TW'(250));
        send_beat(KIND_RETX, '1, TW'(250));
        send_beat(KIND_QUERY, '0, TW'(300));        // ratio far above the Q8.16 range
        send_beat(KIND_SEND, '0, TW'(1000));
        send_beat(KIND_QUERY, '0, TW'(1050));       // zero sends left, no retransmits
        send_beat(KIND_QUERY, '0, TW'(2000));
        send_beat(KIND_RETX, '0, TW'(2000));
        send_beat(KIND_QUERY, '0, TW'(2000));       // retransmit entry of count zero only
        send_beat(KIND_SEND, '1, LAST_STAMP);
        send_beat(KIND_RETX, '1, LAST_STAMP);
        send_beat(KIND_QUERY, '0, LAST_STAMP);
        send_beat(KIND_SEND, 16'd7, TW'(50));       // time steps backwards
        send_beat(KIND_QUERY, '0, TW'(60));
        send_beat(KIND_QUERY, '0, TW'(500));        // newest-stamped entry blocks the prune

        run_phase(WINDOW_W'(1), 270, 2);
        run_phase(WINDOW_W'(50), 270, 3);
        run_phase(WINDOW_RESET, 270, 40000);
        run_phase({8'($urandom_range(1, 255)), 32'($urandom())}, 270, 32'h4000_0000);
        run_phase('1, 270, 32'hFFFF_FFFF);
        calm = 1'b1;
        run_phase(WINDOW_W'(300), 270, 10);

        wait_drained(64);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
